FILE: design/scc_pkg.sv
// Package for the strip cluster centroid block.
// Holds field widths, register indexes and the controller/datapath interface types.
// Depends on nothing; every other file in the design imports it.
package scc_pkg;

    localparam int MAX_CLUSTER_HITS  = 32;
    localparam int STRIP_BITS        = 9;
    localparam int ADC_BITS          = 10;
    localparam int PLANES_PER_SECTOR = 16;

    localparam int DET_W     = 6;
    localparam int AMP_W     = 15;
    localparam int WTOT_W    = 24;
    localparam int CENT_W    = 17;
    localparam int FRAC_W    = 8;
    localparam int ERR_W     = 16;
    localparam int HIT_CNT_W = $clog2(MAX_CLUSTER_HITS + 1);
    localparam int DIV_CNT_W = $clog2(CENT_W);
    localparam int SAT_SHIFT = CENT_W - FRAC_W;

    localparam int CFG_IDX_W  = 3;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_ERR_SINGLE_DEF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_MULTI_DEF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_SINGLE_S2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_MULTI_S2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_SINGLE_S3  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_MULTI_S3   = 3'd5;

    localparam logic [ERR_W-1:0] RST_ERR_SINGLE_DEF = 16'd18219;
    localparam logic [ERR_W-1:0] RST_ERR_MULTI_DEF  = 16'd5898;
    localparam logic [ERR_W-1:0] RST_ERR_SINGLE_S2  = 16'd18220;
    localparam logic [ERR_W-1:0] RST_ERR_MULTI_S2   = 16'd5902;
    localparam logic [ERR_W-1:0] RST_ERR_SINGLE_S3  = 16'd18224;
    localparam logic [ERR_W-1:0] RST_ERR_MULTI_S3   = 16'd5915;

    typedef struct packed {
        logic hit_take;
        logic cluster_end;
        logic div_step;
        logic out_load;
    } scc_cmd_t;

    typedef struct packed {
        logic out_free;
    } scc_sts_t;

endpackage

FILE: design/strip_cluster_centroid.sv
// Strip cluster centroid: center-of-gravity position of one strip cluster.
// Top level; depends on scc_pkg, scc_ctrl and scc_datapath.
//
// Hits enter on the s_ channel, one strip hit per transfer, with s_tlast set
// on the last hit of a cluster; hits are accepted in the accumulate state.
// On the last hit the sums go to a bit-serial restoring divider that yields
// one quotient bit per cycle, so the block is closed to input while it
// divides and until the result is loaded into the output register, which
// holds it and raises m_tvalid. While the receiver stalls, the next
// cluster's hits are still accepted and summed; the next result's hand-off
// waits for the register to drain, and input stays closed while it waits.
// The error registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while the block is idle, as the block itself
// does not enforce it. Indexes 6 and 7 are ignored.
// Reset clears the sums, the output valid flag and the controller, and loads
// the error registers with their default values.
module strip_cluster_centroid
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [scc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [scc_pkg::ERR_W-1:0]           cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // strip_index[8:0], amplitude[18:9], detector_id[24:19], zero fill.
    input  logic [scc_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // centroid[16:0], position_error[32:17], first_strip[41:33], zero fill.
    output logic [scc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // empty_cluster[0].
    output logic                                m_tuser
);
    import scc_pkg::*;

    localparam int OUT_USED_W = CENT_W + ERR_W + STRIP_BITS;

    scc_cmd_t              cmd;
    scc_sts_t              sts;
    logic [CENT_W-1:0]     centroid;
    logic [ERR_W-1:0]      position_error;
    logic [STRIP_BITS-1:0] first_strip;

    scc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    scc_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .strip_index    (s_tdata[STRIP_BITS-1:0]),
        .amplitude      (s_tdata[STRIP_BITS +: ADC_BITS]),
        .detector_id    (s_tdata[STRIP_BITS + ADC_BITS +: DET_W]),
        .cmd            (cmd),
        .sts            (sts),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .centroid       (centroid),
        .position_error (position_error),
        .empty_cluster  (m_tuser),
        .first_strip    (first_strip)
    );

    assign m_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, first_strip, position_error, centroid};

endmodule

FILE: design/scc_datapath.sv
// Datapath of the strip cluster centroid block: accumulators, error registers,
// a bit-serial restoring divider and the output register.
// Depends on scc_pkg; driven by commands from scc_ctrl.
module scc_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [scc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [scc_pkg::ERR_W-1:0]           cfg_data,
    input  logic [scc_pkg::STRIP_BITS-1:0]      strip_index,
    input  logic [scc_pkg::ADC_BITS-1:0]        amplitude,
    input  logic [scc_pkg::DET_W-1:0]           detector_id,
    input  scc_pkg::scc_cmd_t                   cmd,
    output scc_pkg::scc_sts_t                   sts,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [scc_pkg::CENT_W-1:0]          centroid,
    output logic [scc_pkg::ERR_W-1:0]           position_error,
    output logic                                empty_cluster,
    output logic [scc_pkg::STRIP_BITS-1:0]      first_strip
);
    import scc_pkg::*;

    localparam int PROD_W = STRIP_BITS + ADC_BITS;
    localparam int NUM_ERR = 6;

    logic [ERR_W-1:0]      err_reg [NUM_ERR];

    logic [AMP_W-1:0]      amp_total_reg;
    logic [WTOT_W-1:0]     wt_total_reg;
    logic [STRIP_BITS-1:0] start_reg;
    logic [STRIP_BITS-1:0] charged_reg;
    logic                  seen_reg;
    logic                  spread_reg;
    logic                  mid_reg;
    logic [HIT_CNT_W-1:0]  hit_cnt_reg;

    logic [AMP_W-1:0]      amp_total_next;
    logic [WTOT_W-1:0]     wt_total_next;
    logic [STRIP_BITS-1:0] start_next;
    logic [STRIP_BITS-1:0] charged_next;
    logic                  seen_next;
    logic                  spread_next;
    logic [HIT_CNT_W-1:0]  hit_cnt_next;

    logic [AMP_W:0]        amp_sum;
    logic [PROD_W-1:0]     product;
    logic [WTOT_W:0]       wt_sum;
    logic                  in_window;

    logic [AMP_W-1:0]      rem_reg;
    logic [CENT_W-1:0]     dq_reg;
    logic [AMP_W-1:0]      dsr_reg;
    logic                  sat_reg;
    logic                  empty_reg;
    logic [ERR_W-1:0]      sel_err_reg;
    logic [STRIP_BITS-1:0] first_reg;
    logic [AMP_W:0]        trial;
    logic [AMP_W:0]        trial_diff;

    logic [DET_W-1:0]      det_m1;
    logic [DET_W-1:0]      sec_idx;
    logic                  is_s2;
    logic                  is_s3;
    logic                  single_hit;
    logic [ERR_W-1:0]      err_sel;
    logic                  sat_now;

    logic                  out_valid_reg;
    logic [CENT_W-1:0]     out_cent_reg;
    logic [ERR_W-1:0]      out_err_reg;
    logic                  out_empty_reg;
    logic [STRIP_BITS-1:0] out_first_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg[0] <= RST_ERR_SINGLE_DEF;
            err_reg[1] <= RST_ERR_MULTI_DEF;
            err_reg[2] <= RST_ERR_SINGLE_S2;
            err_reg[3] <= RST_ERR_MULTI_S2;
            err_reg[4] <= RST_ERR_SINGLE_S3;
            err_reg[5] <= RST_ERR_MULTI_S3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ERR_SINGLE_DEF: err_reg[0] <= cfg_data;
                REG_ERR_MULTI_DEF:  err_reg[1] <= cfg_data;
                REG_ERR_SINGLE_S2:  err_reg[2] <= cfg_data;
                REG_ERR_MULTI_S2:   err_reg[3] <= cfg_data;
                REG_ERR_SINGLE_S3:  err_reg[4] <= cfg_data;
                REG_ERR_MULTI_S3:   err_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Accumulation of one hit; sums saturate at their width maximum.
    always_comb
    begin
        in_window     = hit_cnt_reg < HIT_CNT_W'(MAX_CLUSTER_HITS);
        start_next    = mid_reg ? start_reg : strip_index;
        amp_sum       = {1'b0, amp_total_reg} + (AMP_W + 1)'(amplitude);
        product       = PROD_W'(strip_index) * PROD_W'(amplitude);
        wt_sum        = {1'b0, wt_total_reg} + (WTOT_W + 1)'(product);
        amp_total_next = amp_total_reg;
        wt_total_next  = wt_total_reg;
        charged_next   = charged_reg;
        seen_next      = seen_reg;
        spread_next    = spread_reg;
        hit_cnt_next   = hit_cnt_reg;
        if (in_window)
        begin
            amp_total_next = amp_sum[AMP_W] ? {AMP_W{1'b1}} : amp_sum[AMP_W-1:0];
            wt_total_next  = wt_sum[WTOT_W] ? {WTOT_W{1'b1}} : wt_sum[WTOT_W-1:0];
            hit_cnt_next   = hit_cnt_reg + 1'b1;
            if (amplitude != '0)
            begin
                if (!seen_reg)
                begin
                    seen_next    = 1'b1;
                    charged_next = strip_index;
                end
                else if (strip_index != charged_reg)
                begin
                    spread_next = 1'b1;
                end
            end
        end
    end

    // Error register choice by sector and one-strip charge.
    always_comb
    begin
        det_m1     = detector_id - 1'b1;
        sec_idx    = (detector_id == '0) ? '0 : DET_W'(det_m1 / PLANES_PER_SECTOR);
        is_s2      = sec_idx == DET_W'(1);
        is_s3      = sec_idx == DET_W'(2);
        single_hit = seen_next && !spread_next;
        if (is_s2)
            err_sel = single_hit ? err_reg[2] : err_reg[3];
        else if (is_s3)
            err_sel = single_hit ? err_reg[4] : err_reg[5];
        else
            err_sel = single_hit ? err_reg[0] : err_reg[1];
        sat_now = {1'b0, wt_total_next} >= ((WTOT_W + 1)'(amp_total_next) << SAT_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_total_reg <= '0;
            wt_total_reg  <= '0;
            start_reg     <= '0;
            charged_reg   <= '0;
            seen_reg      <= 1'b0;
            spread_reg    <= 1'b0;
            mid_reg       <= 1'b0;
            hit_cnt_reg   <= '0;
        end
        else if (cmd.hit_take)
        begin
            if (cmd.cluster_end)
            begin
                amp_total_reg <= '0;
                wt_total_reg  <= '0;
                start_reg     <= '0;
                charged_reg   <= '0;
                seen_reg      <= 1'b0;
                spread_reg    <= 1'b0;
                mid_reg       <= 1'b0;
                hit_cnt_reg   <= '0;
            end
            else
            begin
                amp_total_reg <= amp_total_next;
                wt_total_reg  <= wt_total_next;
                start_reg     <= start_next;
                charged_reg   <= charged_next;
                seen_reg      <= seen_next;
                spread_reg    <= spread_next;
                mid_reg       <= 1'b1;
                hit_cnt_reg   <= hit_cnt_next;
            end
        end
    end

    // Restoring divider: one quotient bit per step of (weighted << 8) / amp.
    always_comb
    begin
        trial      = {rem_reg, dq_reg[CENT_W-1]};
        trial_diff = trial - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hit_take && cmd.cluster_end)
        begin
            rem_reg     <= wt_total_next[WTOT_W-1:SAT_SHIFT];
            dq_reg      <= {wt_total_next[SAT_SHIFT-1:0], {FRAC_W{1'b0}}};
            dsr_reg     <= amp_total_next;
            sat_reg     <= sat_now;
            empty_reg   <= amp_total_next == '0;
            sel_err_reg <= err_sel;
            first_reg   <= start_next;
        end
        else if (cmd.div_step)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_reg <= trial_diff[AMP_W-1:0];
                dq_reg  <= {dq_reg[CENT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[AMP_W-1:0];
                dq_reg  <= {dq_reg[CENT_W-2:0], 1'b0};
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_cent_reg  <= empty_reg ? '0 : (sat_reg ? {CENT_W{1'b1}} : dq_reg);
            out_err_reg   <= sel_err_reg;
            out_empty_reg <= empty_reg;
            out_first_reg <= first_reg;
        end
    end

    assign sts.out_free   = !out_valid_reg || m_tready;
    assign m_tvalid       = out_valid_reg;
    assign centroid       = out_cent_reg;
    assign position_error = out_err_reg;
    assign empty_cluster  = out_empty_reg;
    assign first_strip    = out_first_reg;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("Output register loaded while a result was still waiting.");
    a_hit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hit_cnt_reg <= HIT_CNT_W'(MAX_CLUSTER_HITS))
        else $error("Hit count ran past the cluster limit.");
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !mid_reg |-> (amp_total_reg == '0 && wt_total_reg == '0 && !seen_reg))
        else $error("Sums not clear between clusters.");
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.hit_take && cmd.cluster_end) |=> !mid_reg)
        else $error("Cluster state not cleared after the last hit.");
`endif

endmodule

FILE: design/scc_ctrl.sv
// Controller of the strip cluster centroid block: accepts hits, sequences the
// divider and hands the result to the output register. Depends on scc_pkg.
module scc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    input  scc_pkg::scc_sts_t sts,
    output scc_pkg::scc_cmd_t cmd
);
    import scc_pkg::*;

    typedef enum logic [2:0] {
        ST_ACC  = 3'b001,
        ST_DIV  = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_CNT_W-1:0]   cnt_next;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        s_tready        = 1'b0;
        cmd.hit_take    = 1'b0;
        cmd.cluster_end = 1'b0;
        cmd.div_step    = 1'b0;
        cmd.out_load    = 1'b0;
        case (state_reg)
            ST_ACC:
            begin
                s_tready        = 1'b1;
                cmd.hit_take    = s_tvalid;
                cmd.cluster_end = s_tvalid && s_tlast;
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(CENT_W - 1))
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("Controller state lost its one-hot code.");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step || cmd.out_load) |-> !cmd.hit_take)
        else $error("Hit taken while the divider or output hand-off was busy.");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cluster_end |=> (state_reg == ST_DIV && cnt_reg == '0))
        else $error("Division did not start after the last hit.");
`endif

endmodule
